[design/weighted_smooth_l1_loss_sum_unit_defines.svh]
// Assertion macros for the weighted smooth L1 loss sum unit.
// Taken in by the checker file; no other dependencies.
`ifndef WEIGHTED_SMOOTH_L1_LOSS_SUM_UNIT_DEFINES_SVH
`define WEIGHTED_SMOOTH_L1_LOSS_SUM_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define WSL1_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, reset masks the check
`define WSL1_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[design/wsl1_pkg.sv]
// Shared types, constants and helpers of the weighted smooth L1 loss sum unit.
// No dependencies; every other design module but the divider imports it.
package wsl1_pkg;

	localparam int DEF_COUNT_WIDTH = 32;
	localparam int DEF_ACC_WIDTH   = 48;

	localparam int FIELD_W     = 32;
	localparam int LOSS_W      = 48;
	localparam int CFG_INDEX_W = 2;
	localparam int QUEUE_DEPTH = 4;

	// datapath widths of the term computation
	localparam int PROD_W    = 64;              // one 32x32 product
	localparam int MAG_W     = 63;              // clipped term magnitude
	localparam int WIDE_W    = PROD_W + 33;     // split product recombined
	localparam int ACC_SUM_W = 65;              // accumulator plus signed term

	localparam logic [FIELD_W-1:0] SIGMA_SQ_RESET     = 32'h0001_0000;
	localparam logic [FIELD_W-1:0] INV_SIGMA_SQ_RESET = 32'h0001_0000;

	// register indexes on the configuration channel
	localparam logic [CFG_INDEX_W-1:0] REG_SIGMA_SQ     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_SIGMA_SQ = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_AVERAGE      = 2'd2;

	typedef struct packed {
		logic [FIELD_W-1:0] sigma_sq;
		logic [FIELD_W-1:0] inv_sigma_sq;
		logic               average;
	} cfg_t;

	// one element after classification by the front end
	typedef struct packed {
		logic [FIELD_W-1:0] dmag;      // |prediction - target|
		logic [FIELD_W-1:0] winmag;    // |inside_weight|
		logic [FIELD_W-1:0] woutmag;   // |outside_weight|
		logic               wneg;      // outside_weight < 0
		logic               last;
	} elem_t;

	function automatic logic [FIELD_W-1:0] mag32(input logic [FIELD_W-1:0] x);
		mag32 = x[FIELD_W-1] ? (~x + 1'b1) : x;
	endfunction

endpackage

[design/wsl1_front.sv]
// Front end: registers one input element and reduces it to magnitudes and signs.
// Depends on wsl1_pkg.
module wsl1_front import wsl1_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FIELD_W-1:0] prediction,
	input  logic [FIELD_W-1:0] target,
	input  logic [FIELD_W-1:0] inside_weight,
	input  logic [FIELD_W-1:0] outside_weight,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output elem_t              out_elem
);

	logic              v_s1;
	elem_t             elem_s1;
	elem_t             elem_d;
	logic [FIELD_W:0]  diff;

	always_comb begin
		diff           = {prediction[FIELD_W-1], prediction} - {target[FIELD_W-1], target};
		elem_d.dmag    = diff[FIELD_W] ? FIELD_W'(~diff + 1'b1) : diff[FIELD_W-1:0];
		elem_d.winmag  = mag32(inside_weight);
		elem_d.woutmag = mag32(outside_weight);
		elem_d.wneg    = outside_weight[FIELD_W-1];
		elem_d.last    = last;
	end

	assign in_ready  = !v_s1 || out_ready;
	assign out_valid = v_s1;
	assign out_elem  = elem_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (out_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			elem_s1 <= elem_d;
		end
	end

endmodule

[design/wsl1_queue.sv]
// Short element queue between front and back end.
// Depends on wsl1_pkg for the element type.
module wsl1_queue import wsl1_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  elem_t push_elem,
	output logic  pop_valid,
	input  logic  pop,
	output elem_t pop_elem
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	elem_t         slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (fill_q != CW'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_elem   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		ptr_next = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_elem;
		end
	end

endmodule

[design/wsl1_div.sv]
// Restoring divider, one quotient bit per cycle, for the per-set average.
// No package dependencies.
module wsl1_div #(
	parameter int DW = 49,
	parameter int CW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [CW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int NW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] steps_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] dvs_q;
	logic [DW-1:0] quo_q;
	logic [CW:0]   rem_sh;
	logic [CW:0]   rem_sub;
	logic          fits;

	always_comb begin
		rem_sh  = {rem_q, quo_q[DW-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		fits    = (rem_sh >= {1'b0, dvs_q});
	end

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				steps_q <= NW'(DW);
			end else if (busy_q) begin
				steps_q <= steps_q - 1'b1;
				if (steps_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
		end
	end

endmodule

[design/wsl1_back.sv]
// Back end: per-element loss term on a shared 32x32 multiplier, saturating
// accumulation, set close-out and output register. Depends on wsl1_pkg.
module wsl1_back import wsl1_pkg::*; #(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int ACC_WIDTH   = DEF_ACC_WIDTH,
	parameter int DW          = ((ACC_WIDTH > COUNT_WIDTH) ? ACC_WIDTH : COUNT_WIDTH) + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              q_valid,
	input  elem_t             q_elem,
	output logic              q_pop,
	output logic              div_start,
	output logic [DW-1:0]     div_dividend,
	output logic [COUNT_WIDTH-1:0] div_divisor,
	input  logic              div_done,
	input  logic [DW-1:0]     div_quotient,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [LOSS_W-1:0] out_loss,
	output logic              out_sat
);

	localparam int RES_W = ((DW + 1) > (LOSS_W + 1)) ? (DW + 1) : (LOSS_W + 1);
	localparam int SW    = ACC_SUM_W;

	localparam logic signed [SW-1:0] ACC_MAX_EXT =
		{{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
	localparam logic signed [SW-1:0] ACC_MIN_EXT = ~ACC_MAX_EXT;
	localparam logic signed [RES_W-1:0] LOSS_MAX_EXT =
		{{(RES_W - LOSS_W + 1){1'b0}}, {(LOSS_W - 1){1'b1}}};
	localparam logic signed [RES_W-1:0] LOSS_MIN_EXT = ~LOSS_MAX_EXT;
	localparam logic [PROD_W-1:0] RND_Q16 = PROD_W'(32'h0000_8000);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_AV       = 4'd1;
	localparam logic [3:0] ST_ZONE     = 4'd2;
	localparam logic [3:0] ST_AA       = 4'd3;
	localparam logic [3:0] ST_SQ       = 4'd4;
	localparam logic [3:0] ST_MLO      = 4'd5;
	localparam logic [3:0] ST_MHI      = 4'd6;
	localparam logic [3:0] ST_MSUM     = 4'd7;
	localparam logic [3:0] ST_HALF     = 4'd8;
	localparam logic [3:0] ST_ACC      = 4'd9;
	localparam logic [3:0] ST_DIV_GO   = 4'd10;
	localparam logic [3:0] ST_DIV_WAIT = 4'd11;
	localparam logic [3:0] ST_EMIT     = 4'd12;

	logic [3:0]               state_q;
	elem_t                    elem_q;
	logic [PROD_W-1:0]        prod_q;
	logic [PROD_W-1:0]        mx_q;
	logic [FIELD_W-1:0]       my_q;
	logic                     ph_q;      // 1: weight step, 0: sigma step
	logic [PROD_W:0]          lo_q;
	logic [MAG_W-1:0]         t_q;
	logic signed [ACC_WIDTH-1:0] acc_q;
	logic [COUNT_WIDTH-1:0]   cnt_q;
	logic                     ovf_q;
	logic                     out_valid_q;
	logic [LOSS_W-1:0]        loss_q;
	logic                     sat_q;

	logic [FIELD_W-1:0]       op_a;
	logic [FIELD_W-1:0]       op_b;
	logic [PROD_W-1:0]        mul_p;
	logic [PROD_W-1:0]        thr;
	logic                     quad;
	logic [PROD_W-1:0]        a_rnd;
	logic [PROD_W-1:0]        lin;
	logic [PROD_W:0]          sq;
	logic [WIDE_W-1:0]        wide;
	logic                     clip;
	logic [MAG_W-1:0]         tmag;
	logic [PROD_W-1:0]        half_sum;
	logic signed [SW-1:0]     acc_ext;
	logic signed [SW-1:0]     term_ext;
	logic signed [SW-1:0]     acc_sum;
	logic [ACC_WIDTH-1:0]     acc_mag;
	logic [RES_W-1:0]         q_ext;
	logic signed [RES_W-1:0]  res_w;
	logic                     res_hi;
	logic                     res_lo;
	logic                     emit_go;

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_AV: begin
				op_a = elem_q.dmag;
				op_b = elem_q.winmag;
			end
			ST_AA: begin
				op_a = mx_q[FIELD_W-1:0];
				op_b = mx_q[FIELD_W-1:0];
			end
			ST_MHI: begin
				op_a = mx_q[PROD_W-1:FIELD_W];
				op_b = my_q;
			end
			default: begin
				op_a = mx_q[FIELD_W-1:0];
				op_b = my_q;
			end
		endcase
		mul_p = op_a * op_b;
	end

	always_comb begin
		// zone test on |v| (Q.32) against the threshold
		thr   = {16'd0, cfg.inv_sigma_sq, 16'd0};
		quad  = (prod_q < thr);
		a_rnd = prod_q + RND_Q16;
		lin   = prod_q - {17'd0, cfg.inv_sigma_sq, 15'd0} + RND_Q16;
		// square rounded to Q.16
		sq    = {1'b0, prod_q} + {1'b0, RND_Q16};
		// split product recombined, rounded, clipped
		wide  = WIDE_W'(lo_q) + {1'b0, prod_q, 32'd0};
		clip  = |wide[WIDE_W-1:MAG_W+16];
		tmag  = clip ? {MAG_W{1'b1}} : wide[MAG_W+15:16];
		half_sum = {1'b0, t_q} + PROD_W'(1);
		// saturating accumulate
		acc_ext  = {{(SW - ACC_WIDTH){acc_q[ACC_WIDTH-1]}}, acc_q};
		term_ext = elem_q.wneg ? -{{(SW - MAG_W){1'b0}}, t_q}
		                       : {{(SW - MAG_W){1'b0}}, t_q};
		acc_sum  = acc_ext + term_ext;
		// close-out value
		acc_mag  = acc_q[ACC_WIDTH-1] ? (~acc_q + 1'b1) : acc_q;
		q_ext    = RES_W'(div_quotient);
		if (cfg.average) begin
			res_w = acc_q[ACC_WIDTH-1] ? -q_ext : q_ext;
		end else begin
			res_w = {{(RES_W - ACC_WIDTH){acc_q[ACC_WIDTH-1]}}, acc_q};
		end
		res_hi  = (res_w > LOSS_MAX_EXT);
		res_lo  = (res_w < LOSS_MIN_EXT);
		emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	end

	assign q_pop        = (state_q == ST_IDLE) && q_valid;
	assign div_start    = (state_q == ST_DIV_GO);
	assign div_dividend = DW'(acc_mag) + DW'(cnt_q >> 1);
	assign div_divisor  = cnt_q;
	assign out_valid    = out_valid_q;
	assign out_loss     = loss_q;
	assign out_sat      = sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= 1'b0;
			acc_q       <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, or drop the delivered one
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_AV;
					end
				end
				ST_AV: begin
					state_q <= ST_ZONE;
				end
				ST_ZONE: begin
					if (quad) begin
						state_q <= ST_AA;
					end else begin
						ph_q    <= 1'b1;
						state_q <= ST_MLO;
					end
				end
				ST_AA: begin
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					ph_q    <= 1'b0;
					state_q <= ST_MLO;
				end
				ST_MLO: begin
					state_q <= ST_MHI;
				end
				ST_MHI: begin
					state_q <= ST_MSUM;
				end
				ST_MSUM: begin
					if (clip) begin
						ovf_q <= 1'b1;
					end
					state_q <= ph_q ? ST_ACC : ST_HALF;
				end
				ST_HALF: begin
					ph_q    <= 1'b1;
					state_q <= ST_MLO;
				end
				ST_ACC: begin
					if (acc_sum > ACC_MAX_EXT) begin
						acc_q <= ACC_MAX_EXT[ACC_WIDTH-1:0];
						ovf_q <= 1'b1;
					end else if (acc_sum < ACC_MIN_EXT) begin
						acc_q <= ACC_MIN_EXT[ACC_WIDTH-1:0];
						ovf_q <= 1'b1;
					end else begin
						acc_q <= acc_sum[ACC_WIDTH-1:0];
					end
					if (cnt_q != {COUNT_WIDTH{1'b1}}) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (!elem_q.last) begin
						state_q <= ST_IDLE;
					end else if (cfg.average) begin
						state_q <= ST_DIV_GO;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (emit_go) begin
						acc_q       <= '0;
						cnt_q       <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (q_pop) begin
			elem_q <= q_elem;
		end
		case (state_q)
			ST_ZONE: begin
				if (quad) begin
					mx_q <= {32'd0, a_rnd[47:16]};
				end else begin
					mx_q <= {16'd0, lin[PROD_W-1:16]};
					my_q <= elem_q.woutmag;
				end
			end
			ST_SQ: begin
				mx_q <= {15'd0, sq[PROD_W:16]};
				my_q <= cfg.sigma_sq;
			end
			ST_MHI: begin
				lo_q <= {1'b0, prod_q} + {1'b0, RND_Q16};
			end
			ST_MSUM: begin
				t_q <= tmag;
			end
			ST_HALF: begin
				mx_q <= {1'b0, half_sum[PROD_W-1:1]};
				my_q <= elem_q.woutmag;
			end
			default: begin
			end
		endcase
		if (emit_go) begin
			if (res_hi) begin
				loss_q <= LOSS_MAX_EXT[LOSS_W-1:0];
			end else if (res_lo) begin
				loss_q <= LOSS_MIN_EXT[LOSS_W-1:0];
			end else begin
				loss_q <= res_w[LOSS_W-1:0];
			end
			sat_q <= ovf_q || res_hi || res_lo;
		end
	end

endmodule

[design/weighted_smooth_l1_loss_sum_unit.sv]
// Top level of the weighted smooth L1 loss sum unit: config registers, front end,
// element queue, back end and divider. Depends on wsl1_pkg and wsl1_front/queue/back/div.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | tdata: 4 x Q16.16 element, tlast: last
//  m_*     | out       | m_tvalid/m_tready  | tdata: loss Q32.16, tuser: saturated
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index: register, cfg_data: value
//
// Back end, linear zone: IDLE, AV, ZONE, MLO, MHI, MSUM, ACC; the quadratic zone
// adds AA, SQ, HALF and a second MLO, MHI, MSUM pass. All products of an element go
// through one shared 32x32 multiplier. A set's last element adds EMIT, and in average
// mode DIV_GO, DIV_WAIT on the DW-bit divider, DW = max(ACC_WIDTH, COUNT_WIDTH) + 1.
// The front end takes one item per cycle until the four-entry queue fills.
// Reset clears all control state and the accumulator; no clearing pass is needed.
// A result waiting on m_tready does not hold up accumulation of the next set.
module weighted_smooth_l1_loss_sum_unit import wsl1_pkg::*; #(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int ACC_WIDTH   = DEF_ACC_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// prediction [31:0], target [63:32], inside_weight [95:64], outside_weight [127:96]
	input  logic [4*FIELD_W-1:0]   s_tdata,
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// loss [47:0]
	output logic [LOSS_W-1:0]      m_tdata,
	// saturated [0]
	output logic                   m_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [FIELD_W-1:0]     cfg_data
);

	localparam int DW = ((ACC_WIDTH > COUNT_WIDTH) ? ACC_WIDTH : COUNT_WIDTH) + 1;

	cfg_t                   cfg_q;
	logic                   fe_valid;
	logic                   fe_ready;
	elem_t                  fe_elem;
	logic                   q_valid;
	logic                   q_pop;
	elem_t                  q_elem;
	logic                   div_start;
	logic [DW-1:0]          div_dividend;
	logic [COUNT_WIDTH-1:0] div_divisor;
	logic                   div_done;
	logic [DW-1:0]          div_quotient;

	// Configuration is always accepted; writes beyond the register list drop.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sigma_sq     <= SIGMA_SQ_RESET;
			cfg_q.inv_sigma_sq <= INV_SIGMA_SQ_RESET;
			cfg_q.average      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SIGMA_SQ:     cfg_q.sigma_sq     <= cfg_data;
				REG_INV_SIGMA_SQ: cfg_q.inv_sigma_sq <= cfg_data;
				REG_AVERAGE:      cfg_q.average      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Front end: difference and magnitudes, one register stage.
	wsl1_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.prediction     (s_tdata[FIELD_W-1:0]),
		.target         (s_tdata[2*FIELD_W-1:FIELD_W]),
		.inside_weight  (s_tdata[3*FIELD_W-1:2*FIELD_W]),
		.outside_weight (s_tdata[4*FIELD_W-1:3*FIELD_W]),
		.last           (s_tlast),
		.out_valid      (fe_valid),
		.out_ready      (fe_ready),
		.out_elem       (fe_elem)
	);

	// Queue decouples the fast front from the multi-cycle back end.
	wsl1_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_elem  (fe_elem),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_elem   (q_elem)
	);

	// Back end: term, accumulation, close-out and output register.
	wsl1_back #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.ACC_WIDTH   (ACC_WIDTH),
		.DW          (DW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_elem       (q_elem),
		.q_pop        (q_pop),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_quotient (div_quotient),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_loss     (m_tdata),
		.out_sat      (m_tuser)
	);

	// Average: rounded quotient of |sum| + count/2 by count.
	wsl1_div #(
		.DW (DW),
		.CW (COUNT_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

endmodule

[design/wsl1_chk.sv]
// Port-level checker for the weighted smooth L1 loss sum unit, bound to the top.
// Depends on wsl1_pkg and the assertion macros header.
`include "weighted_smooth_l1_loss_sum_unit_defines.svh"

module wsl1_chk import wsl1_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              s_tlast,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [LOSS_W-1:0] m_tdata,
	input logic              m_tuser
);

	// front stage, queue, back end element and output register
	localparam logic [7:0] PEND_MAX = 8'(QUEUE_DEPTH + 3);

	logic [7:0] pend_q;
	logic       set_in;
	logic       set_out;

	assign set_in  = s_tvalid && s_tready && s_tlast;
	assign set_out = m_tvalid && m_tready;

	// count closed sets whose result is not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (set_in && !set_out) begin
			pend_q <= pend_q + 1'b1;
		end else if (set_out && !set_in) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	`WSL1_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`WSL1_ASSERT_IMP(a_out_has_set, clk, arst_n, m_tvalid, pend_q != 8'd0, "result without a closed set")
	`WSL1_ASSERT_IMP(a_pend_bound, clk, arst_n, 1'b1, pend_q <= PEND_MAX, "too many open results")

endmodule

bind weighted_smooth_l1_loss_sum_unit wsl1_chk u_wsl1_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[bench/tb_top.sv]
// Self-checking bench for weighted_smooth_l1_loss_sum_unit: streams element sets,
// predicts each set's loss and saturation flag, and compares every result item.
// Depends on wsl1_pkg and the design files under design/.
module tb_top;
	import wsl1_pkg::*;

	localparam int ACC_W        = DEF_ACC_WIDTH;
	localparam int CNT_W        = DEF_COUNT_WIDTH;
	localparam int CYCLE_LIMIT  = 500000;
	// worst back-end time for a few queued elements plus the average divider
	localparam int SETTLE       = 120;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 88;

	localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam longint ACC_MAX  = (64'sd1 <<< (ACC_W - 1)) - 1;
	localparam longint ACC_MIN  = -ACC_MAX - 1;
	localparam longint LOSS_MAX = (64'sd1 <<< (LOSS_W - 1)) - 1;
	localparam longint LOSS_MIN = -LOSS_MAX - 1;

	localparam logic [31:0] Q_ONE  = 32'h0001_0000;
	localparam logic [31:0] Q_HALF = 32'h0000_8000;
	localparam logic [31:0] Q_MAXP = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MAXN = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] pred;
		logic [31:0] tgt;
		logic [31:0] win;
		logic [31:0] wout;
		logic        last;
	} loss_elem_t;

	typedef struct packed {
		logic [LOSS_W-1:0] loss;
		logic              sat;
	} loss_result_t;

	// DUT connections; every input starts at a known value
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [4*FIELD_W-1:0]   s_tdata   = '0;
	logic                   s_tlast   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [LOSS_W-1:0]      m_tdata;
	logic                   m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_SIGMA_SQ;
	logic [FIELD_W-1:0]     cfg_data  = '0;

	// stimulus and scoreboard
	loss_elem_t   element_q[$];
	loss_result_t loss_expect_q[$];
	loss_result_t exp_r;
	loss_elem_t   cur_elem;
	int           queued_cnt   = 0;
	int           accepted_cnt = 0;
	int           err_cnt      = 0;
	int           cycle_cnt    = 0;
	int           gap_pct      = 0;
	int           stall_pct    = 0;
	int           src_gap      = 0;
	int           snk_gap      = 0;
	bit           s_took       = 1'b0;

	// predictor state and its copy of the registers
	logic [31:0]             cfg_sigma_sq     = SIGMA_SQ_RESET;
	logic [31:0]             cfg_inv_sigma_sq = INV_SIGMA_SQ_RESET;
	logic                    cfg_average      = 1'b0;
	logic signed [ACC_W-1:0] sum_acc          = '0;
	logic [CNT_W-1:0]        elem_count       = '0;
	logic                    clip_seen        = 1'b0;

	weighted_smooth_l1_loss_sum_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Unsigned Q16 product rounded half up; clip at 2^63-1 and flag it.
	function logic [63:0] mul_round_q16(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b} + 128'h8000) >> 16;
		if (p > {64'd0, MAG_LIMIT}) begin
			clip_seen = 1'b1;
			mul_round_q16 = MAG_LIMIT;
		end else begin
			mul_round_q16 = p[63:0];
		end
	endfunction

	// Signed loss term of one element, Q.16.
	function logic signed [63:0] element_term(input loss_elem_t e);
		longint      d;
		longint      w_in;
		longint      w_out;
		logic [63:0] dmag;
		logic [63:0] winmag;
		logic [63:0] av;
		logic [63:0] a;
		logic [63:0] s;
		logic [63:0] t;
		logic [63:0] h;
		d      = longint'($signed(e.pred)) - longint'($signed(e.tgt));
		w_in   = longint'($signed(e.win));
		w_out  = longint'($signed(e.wout));
		dmag   = (d < 0) ? 64'(-d) : 64'(d);
		winmag = (w_in < 0) ? 64'(-w_in) : 64'(w_in);
		// |v| stays exact in Q.32
		av     = dmag * winmag;
		if (av < ({32'd0, cfg_inv_sigma_sq} << 16)) begin
			// quadratic zone: 0.5 * v^2 * sigma^2
			a = (av + 64'h8000) >> 16;
			s = mul_round_q16(a, a);
			t = mul_round_q16(s, {32'd0, cfg_sigma_sq});
			h = (t + 64'd1) >> 1;
		end else begin
			// linear zone: |v| - 0.5/sigma^2, exact before rounding
			h = (av - ({32'd0, cfg_inv_sigma_sq} << 15) + 64'h8000) >> 16;
		end
		t = mul_round_q16(h, (w_out < 0) ? 64'(-w_out) : 64'(w_out));
		element_term = (w_out < 0) ? -$signed(t) : $signed(t);
	endfunction

	// Fold one accepted element into the running sum; emit the expected item on last.
	function void accumulate_element(input loss_elem_t e);
		logic signed [63:0] term;
		logic signed [65:0] sum;
		logic signed [63:0] res;
		logic [63:0]        m;
		logic [63:0]        q;
		loss_result_t       r;
		term = element_term(e);
		sum  = $signed(sum_acc) + $signed(term);
		if (sum > ACC_MAX) begin
			sum_acc   = ACC_MAX[ACC_W-1:0];
			clip_seen = 1'b1;
		end else if (sum < ACC_MIN) begin
			sum_acc   = ACC_MIN[ACC_W-1:0];
			clip_seen = 1'b1;
		end else begin
			sum_acc = sum[ACC_W-1:0];
		end
		if (elem_count != '1)
			elem_count = elem_count + 1'b1;
		if (e.last) begin
			res = sum_acc;
			if (cfg_average) begin
				// round half away from zero on the magnitude
				m   = (res < 0) ? 64'(-res) : 64'(res);
				q   = (m + {32'd0, elem_count} / 2) / {32'd0, elem_count};
				res = (res < 0) ? -$signed(q) : $signed(q);
			end
			if (res > LOSS_MAX) begin
				res       = LOSS_MAX;
				clip_seen = 1'b1;
			end else if (res < LOSS_MIN) begin
				res       = LOSS_MIN;
				clip_seen = 1'b1;
			end
			r.loss = res[LOSS_W-1:0];
			r.sat  = clip_seen;
			loss_expect_q.push_back(r);
			sum_acc    = '0;
			elem_count = '0;
			clip_seen  = 1'b0;
		end
	endfunction

	// Source: hold the item until it is taken, then advance or open a gap.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_took)) begin
			if (src_gap > 0) begin
				src_gap  = src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (element_q.size() > 0) begin
				cur_elem = element_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {cur_elem.wout, cur_elem.win, cur_elem.tgt, cur_elem.pred};
				s_tlast  <= cur_elem.last;
				if ($urandom_range(99) < gap_pct)
					src_gap = $urandom_range(5, 1);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Sink: stall in short random bursts.
	always @(negedge clk) begin
		if (arst_n) begin
			if (snk_gap > 0) begin
				snk_gap  = snk_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(99) < stall_pct)
					snk_gap = $urandom_range(5, 1);
			end
		end
	end

	// Monitor: check the result item first, then predict from the accepted element.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (loss_expect_q.size() == 0) begin
					$error("result item with nothing expected: loss %h saturated %b",
						m_tdata, m_tuser);
					err_cnt++;
				end else begin
					exp_r = loss_expect_q.pop_front();
					if (m_tdata !== exp_r.loss) begin
						$error("loss: expected %h, actual %h", exp_r.loss, m_tdata);
						err_cnt++;
					end
					if (m_tuser !== exp_r.sat) begin
						$error("saturated: expected %b, actual %b", exp_r.sat, m_tuser);
						err_cnt++;
					end
				end
			end
			s_took = s_tvalid && s_tready;
			if (s_took) begin
				accumulate_element({s_tdata[31:0], s_tdata[63:32], s_tdata[95:64],
					s_tdata[127:96], s_tlast});
				accepted_cnt++;
			end
		end
	end

	// Watchdog: a hang ends the run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic push_elem(input logic [31:0] pred, input logic [31:0] tgt,
		input logic [31:0] win, input logic [31:0] wout, input logic last);
		loss_elem_t e;
		e = '{pred: pred, tgt: tgt, win: win, wout: wout, last: last};
		element_q.push_back(e);
		queued_cnt++;
	endtask

	// Write one register; update the predictor's copy at the handshake.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SIGMA_SQ:     cfg_sigma_sq     = val;
			REG_INV_SIGMA_SQ: cfg_inv_sigma_sq = val;
			REG_AVERAGE:      cfg_average      = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Hold off until every element is taken and every result has come, then settle.
	task automatic wait_idle();
		while (accepted_cnt != queued_cnt || loss_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_reg_value();
		case ($urandom_range(5))
			0:       return 32'hFFFF_FFFF;
			1:       return 32'd0;
			2, 3:    return 32'($urandom_range(32'h0004_0000));
			default: return $urandom();
		endcase
	endfunction

	// Signed Q16.16 operand: small, medium, extreme or fully random.
	function automatic logic [31:0] rand_q(input bit mild, input logic [31:0] span);
		if (mild)
			return 32'($urandom_range(2 * span)) - span;
		case ($urandom_range(9))
			0, 1, 2: return $urandom();
			3, 4:    return 32'($urandom_range(32'h0080_0000)) - 32'h0040_0000;
			5, 6:    return 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
			7: begin
				case ($urandom_range(4))
					0:       return Q_MAXP;
					1:       return Q_MAXN;
					2:       return 32'hFFFF_FFFF;
					3:       return Q_ONE;
					default: return 32'd0;
				endcase
			end
			default: return 32'($urandom_range(32'h0000_4000)) - 32'h0000_2000;
		endcase
	endfunction

	// One set of random elements; most sets stay small so sums rarely clip.
	task automatic add_random_set(output int n);
		bit mild;
		n    = ($urandom_range(9) == 0) ? $urandom_range(30, 9) : $urandom_range(8, 1);
		mild = ($urandom_range(3) != 0);
		for (int i = 0; i < n; i++)
			push_elem(rand_q(mild, 32'h0004_0000), rand_q(mild, 32'h0004_0000),
				rand_q(mild, 32'h0002_0000), rand_q(mild, 32'h0002_0000), i == n - 1);
	endtask

	initial begin
		int n;
		int added;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: sigma^2 = 1.0, threshold 1.0, plain sum.
		gap_pct   = 30;
		stall_pct = 30;
		push_elem(32'd0, 32'd0, Q_ONE, Q_ONE, 1'b1);             // one-element set, zero loss
		push_elem(Q_HALF, 32'd0, Q_ONE, Q_ONE, 1'b0);            // quadratic zone
		push_elem(Q_ONE, 32'd0, Q_ONE, Q_ONE, 1'b0);             // exactly on threshold: linear
		push_elem(Q_ONE - 1, 32'd0, Q_ONE, Q_ONE, 1'b0);         // just under threshold
		push_elem(32'hFFFD_0000, 32'd0, Q_ONE, 32'hFFFF_0000, 1'b1); // negative outside weight
		push_elem(Q_MAXP, Q_MAXN, Q_MAXN, Q_MAXP, 1'b0);         // clip high
		push_elem(Q_MAXP, Q_MAXN, Q_MAXN, Q_MAXN, 1'b1);         // then swing to clip low
		push_elem(Q_MAXN, Q_MAXP, Q_MAXP, Q_MAXN, 1'b1);         // negative overflow alone
		push_elem(Q_MAXP, 32'hFFFF_FFFF, 32'd0, Q_MAXP, 1'b1);   // zero inside weight
		wait_idle();

		// Largest sigma^2 and threshold, averaging on.
		write_reg(REG_SIGMA_SQ, 32'hFFFF_FFFF);
		write_reg(REG_INV_SIGMA_SQ, 32'hFFFF_FFFF);
		write_reg(REG_AVERAGE, 32'd1);
		push_elem(Q_ONE, 32'd0, Q_ONE, Q_ONE, 1'b0);
		push_elem(Q_MAXP, Q_MAXN, Q_MAXN, Q_MAXP, 1'b0);
		push_elem(32'hFFFF_FFFF, 32'h0000_0001, Q_ONE, 32'hFFFF_FFFF, 1'b1);
		push_elem(32'h0000_0003, 32'd0, Q_ONE, Q_ONE, 1'b0);     // average rounding
		push_elem(32'hFFFF_FFFE, 32'd0, Q_ONE, Q_MAXN, 1'b1);
		push_elem(32'h0000_0100, 32'd0, Q_ONE, Q_ONE, 1'b1);
		wait_idle();

		// Zero sigma^2 and zero threshold: everything falls in the linear zone.
		write_reg(REG_SIGMA_SQ, 32'd0);
		write_reg(REG_INV_SIGMA_SQ, 32'd0);
		write_reg(REG_AVERAGE, 32'd0);
		push_elem(32'd0, 32'd0, Q_ONE, Q_ONE, 1'b0);
		push_elem(32'h0000_0001, 32'd0, 32'h0000_0001, Q_MAXP, 1'b0);
		push_elem(32'h0001_8000, Q_MAXN, Q_HALF, 32'hFFFF_8000, 1'b1);
		wait_idle();

		// Random phases, each under fresh settings; the last one runs with no source gaps or sink stalls.
		for (int p = 0; p < RAND_PHASES; p++) begin
			write_reg(REG_SIGMA_SQ, rand_reg_value());
			write_reg(REG_INV_SIGMA_SQ, rand_reg_value());
			write_reg(REG_AVERAGE, 32'($urandom_range(1)));
			if (p == RAND_PHASES - 1) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = 20 * $urandom_range(2);
				stall_pct = 20 * $urandom_range(2);
			end
			added = 0;
			while (added < PHASE_ITEMS) begin
				add_random_set(n);
				added += n;
			end
			wait_idle();
		end

		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
